[src/ofcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcd_pkg
// shared types and constants of the offset framed command deframer
// ----------------------------------------------------------------------------
package ofcd_pkg;

    localparam int WinLen     = 9;
    localparam int InnerLen   = WinLen - 2;
    localparam int QueueDepth = 2;
    localparam int CfgIdxW    = 2;

    localparam logic [7:0] StartReset  = 8'd36;
    localparam logic [7:0] EndReset    = 8'd35;
    localparam logic [7:0] OffsetReset = 8'd14;

    localparam logic [CfgIdxW-1:0] RegStart  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegEnd    = 2'd1;
    localparam logic [CfgIdxW-1:0] RegOffset = 2'd2;

    typedef enum logic [1:0] {
        StOk     = 2'd0,
        StChkErr = 2'd1,
        StNan    = 2'd2
    } t_status;

    // raw inner bytes of a matched window, index 0 is the command byte
    typedef logic [InnerLen-1:0][7:0] t_inner;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] byte_offset;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[src/ofcd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcd_if
// valid/ready channel interfaces for received bytes, results and config
// ----------------------------------------------------------------------------
interface ofcd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ofcd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command;
    logic [31:0] payload_bits;
    logic [1:0]  status;
    modport source (output valid, output command, output payload_bits, output status,
                    input ready);
    modport sink   (input valid, input command, input payload_bits, input status,
                    output ready);
endinterface

interface ofcd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ofcd_pkg::CfgIdxW-1:0]  index;
    logic [7:0]                    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/ofcd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcd_front
// sliding byte window and frame marker match, pushes matched frames
// ----------------------------------------------------------------------------
module ofcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ofcd_rx_if.sink             i_rx,
    input  ofcd_pkg::t_cfg      i_cfg,
    input  ofcd_pkg::t_q_status i_q_status,
    output logic                o_push,
    output ofcd_pkg::t_inner    o_frame
);

    logic [7:0] r_win [ofcd_pkg::WinLen];
    logic       w_accept;
    logic       w_match;

    assign i_rx.ready = !i_q_status.full;
    assign w_accept   = i_rx.valid && i_rx.ready;

    // window after the shift: oldest is r_win[1], newest is the incoming byte
    assign w_match = (r_win[1] == i_cfg.start_marker) && (i_rx.rx_byte == i_cfg.end_marker);
    assign o_push  = w_accept && w_match;

    always_comb begin
        for (int i = 0; i < ofcd_pkg::InnerLen; i++) begin
            o_frame[i] = r_win[i+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ofcd_pkg::WinLen; i++) begin
                r_win[i] <= 8'd0;
            end
        end else if (w_accept) begin
            for (int i = 0; i < ofcd_pkg::WinLen - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[ofcd_pkg::WinLen-1] <= i_rx.rx_byte;
        end
    end

`ifndef SYNTH
    a_push_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_rx.rx_byte == i_cfg.end_marker) && !i_q_status.full)
        else $error("frame pushed without end marker or into full queue");
`endif

endmodule

[src/ofcd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcd_queue
// short frame queue between the window front and the decode back
// ----------------------------------------------------------------------------
module ofcd_queue #(
    parameter int DEPTH = ofcd_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ofcd_pkg::t_inner    i_data,
    input  logic                i_pop,
    output ofcd_pkg::t_inner    o_data,
    output ofcd_pkg::t_q_status o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    ofcd_pkg::t_inner r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CntW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");
`endif

endmodule

[src/ofcd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofcd_back
// removes the byte offset, checks checksum and nan, holds the result
// ----------------------------------------------------------------------------
module ofcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ofcd_pkg::t_cfg      i_cfg,
    input  ofcd_pkg::t_q_status i_q_status,
    input  ofcd_pkg::t_inner    i_frame,
    output logic                o_pop,
    ofcd_res_if.source          o_res
);

    ofcd_pkg::t_inner  w_dec;
    logic [31:0]       w_payload;
    logic [15:0]       w_sum;
    logic [15:0]       w_check;
    logic              w_nan;
    ofcd_pkg::t_status w_status;

    logic              r_valid;
    logic [7:0]        r_command;
    logic [31:0]       r_payload;
    ofcd_pkg::t_status r_status;

    always_comb begin
        for (int i = 0; i < ofcd_pkg::InnerLen; i++) begin
            w_dec[i] = i_frame[i] - i_cfg.byte_offset;
        end
    end

    assign w_payload = {w_dec[1], w_dec[2], w_dec[3], w_dec[4]};
    assign w_sum     = {8'd0, w_dec[0]} + {8'd0, w_dec[1]} + {8'd0, w_dec[2]}
                     + {8'd0, w_dec[3]} + {8'd0, w_dec[4]};
    assign w_check   = {w_dec[5], w_dec[6]};
    assign w_nan     = (w_payload[30:23] == 8'hFF) && (w_payload[22:0] != 23'd0);

    always_comb begin
        if (w_sum != w_check) begin
            w_status = ofcd_pkg::StChkErr;
        end else if (w_nan) begin
            w_status = ofcd_pkg::StNan;
        end else begin
            w_status = ofcd_pkg::StOk;
        end
    end

    assign o_pop = !i_q_status.empty && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_command <= w_dec[0];
            r_payload <= w_payload;
            r_status  <= w_status;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.command      = r_command;
    assign o_res.payload_bits = r_payload;
    assign o_res.status       = r_status;

`ifndef SYNTH
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status != 2'd3))
        else $error("illegal status code");
    a_pop_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped frame not held in result register");
`endif

endmodule

[src/offset_framed_command_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_framed_command_deframer
// received bytes enter a nine-byte window; when the oldest byte is the start
// marker and the newest the end marker, the seven inner bytes lose the
// offset and give command, float payload and a checked status
//
// channels: i_rx carries one rx_byte per transfer, o_res one result per
// matched frame (command, payload_bits, status), i_cfg writes start_marker
// (index 0), end_marker (1) and byte_offset (2); other indexes are dropped
// path: the end marker transfer writes the matched frame into the frame queue,
// and from there it is popped into the result register that drives o_res
// throughput: one byte per cycle; the front window stalls only when the
// frame queue is full, which happens only while o_res is held off
// reset: window cleared to zero, markers '$' and '#', offset 14, queue and
// result register empty; the cleared window takes part in matching
// receiver stall: the result register holds, the queue fills with up to
// QUEUE_DEPTH more frames, then i_rx.ready drops until o_res drains
// ----------------------------------------------------------------------------
module offset_framed_command_deframer #(
    parameter int QUEUE_DEPTH = ofcd_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ofcd_rx_if.sink     i_rx,
    ofcd_res_if.source  o_res,
    ofcd_cfg_if.sink    i_cfg
);

    ofcd_pkg::t_cfg      r_cfg;
    ofcd_pkg::t_q_status w_q_status;
    ofcd_pkg::t_inner    w_push_frame;
    ofcd_pkg::t_inner    w_pop_frame;
    logic                w_push;
    logic                w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= ofcd_pkg::StartReset;
            r_cfg.end_marker   <= ofcd_pkg::EndReset;
            r_cfg.byte_offset  <= ofcd_pkg::OffsetReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                ofcd_pkg::RegStart:  r_cfg.start_marker <= i_cfg.data;
                ofcd_pkg::RegEnd:    r_cfg.end_marker   <= i_cfg.data;
                ofcd_pkg::RegOffset: r_cfg.byte_offset  <= i_cfg.data;
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    ofcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_cfg      (r_cfg),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_frame    (w_push_frame)
    );

    ofcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_frame),
        .i_pop    (w_pop),
        .o_data   (w_pop_frame),
        .o_status (w_q_status)
    );

    ofcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (w_q_status),
        .i_frame    (w_pop_frame),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule
